// ----- hw/rtl/point_set_unit_cube_normalize_unit_macros.svh -----
// Assertion macros shared by the point set normalizer RTL.
// Both macros sample on clk_i and are disabled while rst_ni is low.
`ifndef POINT_SET_UNIT_CUBE_NORMALIZE_UNIT_MACROS_SVH
`define POINT_SET_UNIT_CUBE_NORMALIZE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PSCN_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("pscn assertion failed");
`define PSCN_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pscn assertion failed");
`else
`define PSCN_ASSERT(name, prop)
`define PSCN_ASSERT_NEXT(name, ante, cons)
`endif
`endif

// ----- hw/rtl/pscn_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and inter-module structs of the point set normalizer.
// No dependencies; every RTL module imports this package.
package pscn_pkg;

  localparam int unsigned MAX_POINTS    = 1024;
  localparam int unsigned COORD_BITS    = 24;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int unsigned SCALE_BITS    = 16;
  localparam int unsigned OUT_BITS      = 32;
  localparam int unsigned INDEX_BITS    = 10;
  localparam int unsigned KIND_BITS     = 2;
  localparam int unsigned STATUS_BITS   = 2;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam int unsigned NUM_AXES      = 3;

  localparam int unsigned ADDR_W  = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int unsigned STORE_W = NUM_AXES * COORD_BITS;

  // Divider geometry: numerator is d * scale * 2^(FRAC_BITS-8).
  localparam int unsigned SHIFT_S = FRAC_BITS - 8;
  localparam int unsigned PROD_W  = COORD_BITS + SCALE_BITS;
  localparam int unsigned NUM_W   = PROD_W + SHIFT_S;
  localparam int unsigned DIV_W   = COORD_BITS + 1;
  localparam int unsigned QUOT_W  = (NUM_W < OUT_BITS + 1) ? NUM_W : OUT_BITS + 1;
  localparam int unsigned QCNT_W  = $clog2(QUOT_W);
  localparam int unsigned CMP_W   = (NUM_W > DIV_W) ? NUM_W : DIV_W;
  localparam int unsigned VAL_W   = (QUOT_W + 2 > OUT_BITS + 1) ? QUOT_W + 2 : OUT_BITS + 1;

  localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(256);

  localparam logic [CFG_IDX_BITS-1:0] CFG_SCALE  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER = CFG_IDX_BITS'(1);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NO_POINT = 2'd1,
    STATUS_FLAT     = 2'd2
  } status_e;

  typedef struct packed {
    logic                  start;
    logic                  center;
    logic [SCALE_BITS-1:0] scale;
    logic [DIV_W-1:0]      divisor;
  } lane_cmd_t;

  typedef struct packed {
    logic [QUOT_W-1:0] quot;
    logic              inexact;
    logic              neg;
  } lane_res_t;

  typedef struct packed {
    logic    valid;
    status_e status;
  } err_req_t;

endpackage

// ----- hw/rtl/pscn_lane.sv -----
`timescale 1ns / 1ps
// One axis lane: offset, optional centering, scale multiply and a restoring divider.
// Depends on pscn_pkg and the assertion macro header.
`include "point_set_unit_cube_normalize_unit_macros.svh"
module pscn_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pscn_pkg::lane_cmd_t             cmd_i,
  input  pscn_pkg::coord_t                coord_i,
  input  pscn_pkg::coord_t                box_min_i,
  input  logic [pscn_pkg::COORD_BITS-1:0] ext_i,
  output logic                            done_o,
  output pscn_pkg::lane_res_t             res_o
);
  import pscn_pkg::*;

  typedef enum logic [2:0] {
    L_IDLE,
    L_PREP,
    L_MUL,
    L_INIT,
    L_DIV,
    L_DONE
  } lane_state_e;

  lane_state_e             state_q;
  logic [COORD_BITS-1:0]   d_q;
  logic [COORD_BITS-1:0]   ext_q;
  logic [DIV_W-1:0]        div_q;
  logic                    center_q;
  logic [SCALE_BITS-1:0]   scale_q;
  logic [COORD_BITS-1:0]   mag_q;
  logic                    neg_q;
  logic [PROD_W-1:0]       prod_q;
  logic [DIV_W-1:0]        rem_q;
  logic [QUOT_W-1:0]       sh_q;
  logic                    sat_q;
  logic [QCNT_W-1:0]       cnt_q;

  logic signed [COORD_BITS:0]   diff;
  logic signed [COORD_BITS+1:0] cent;
  logic [COORD_BITS+1:0]        cent_abs;
  logic [NUM_W-1:0]             num;
  logic [NUM_W-1:0]             num_hi;
  logic                         ovf;
  logic [DIV_W:0]               trial;
  logic [DIV_W:0]               trial_sub;
  logic                         ge;

  assign diff = $signed({coord_i[COORD_BITS-1], coord_i})
              - $signed({box_min_i[COORD_BITS-1], box_min_i});

  // Center mode works on 2d - e, whose magnitude never exceeds the extent.
  assign cent     = $signed({1'b0, d_q, 1'b0}) - $signed({2'b00, ext_q});
  assign cent_abs = cent[COORD_BITS+1] ? $unsigned(-cent) : $unsigned(cent);

  assign num    = NUM_W'(prod_q) << SHIFT_S;
  assign num_hi = num >> QUOT_W;
  // If the bits above the quotient window already reach the divisor,
  // the quotient does not fit and the result saturates anyway.
  assign ovf    = CMP_W'(num_hi) >= CMP_W'(div_q);

  assign trial     = {rem_q, sh_q[QUOT_W-1]};
  assign ge        = trial >= {1'b0, div_q};
  assign trial_sub = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        L_IDLE: begin
          if (cmd_i.start) begin
            d_q      <= diff[COORD_BITS-1:0];
            ext_q    <= ext_i;
            div_q    <= cmd_i.divisor;
            center_q <= cmd_i.center;
            scale_q  <= cmd_i.scale;
            state_q  <= L_PREP;
          end
        end
        L_PREP: begin
          mag_q   <= center_q ? cent_abs[COORD_BITS-1:0] : d_q;
          neg_q   <= center_q & cent[COORD_BITS+1];
          state_q <= L_MUL;
        end
        L_MUL: begin
          prod_q  <= {{SCALE_BITS{1'b0}}, mag_q} * {{COORD_BITS{1'b0}}, scale_q};
          state_q <= L_INIT;
        end
        L_INIT: begin
          sat_q   <= ovf;
          rem_q   <= ovf ? '0 : num_hi[DIV_W-1:0];
          sh_q    <= num[QUOT_W-1:0];
          cnt_q   <= '0;
          state_q <= L_DIV;
        end
        L_DIV: begin
          rem_q <= ge ? trial_sub[DIV_W-1:0] : trial[DIV_W-1:0];
          sh_q  <= {sh_q[QUOT_W-2:0], ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == QCNT_W'(QUOT_W - 1)) begin
            state_q <= L_DONE;
          end
        end
        L_DONE: begin
          state_q <= L_IDLE;
        end
        default: begin
          state_q <= L_IDLE;
        end
      endcase
    end
  end

  assign done_o        = state_q == L_DONE;
  assign res_o.quot    = sat_q ? '1 : sh_q;
  assign res_o.inexact = sat_q | (rem_q != '0);
  assign res_o.neg     = neg_q;

  `PSCN_ASSERT(a_start_when_idle, cmd_i.start |-> state_q == L_IDLE)
  `PSCN_ASSERT_NEXT(a_done_single, done_o, !done_o)
  `PSCN_ASSERT(a_rem_below_div, state_q == L_DIV |-> rem_q < div_q)

endmodule

// ----- hw/rtl/pscn_merge.sv -----
`timescale 1ns / 1ps
// Merge stage: signs, offsets and saturates the lane quotients into one result item.
// Also forwards error results; depends on pscn_pkg.
module pscn_merge (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [pscn_pkg::NUM_AXES-1:0]    done_i,
  input  pscn_pkg::lane_res_t              res_i [pscn_pkg::NUM_AXES],
  input  logic                             center_i,
  input  pscn_pkg::err_req_t               err_i,
  output logic                             valid_o,
  output logic signed [pscn_pkg::OUT_BITS-1:0] norm_o [pscn_pkg::NUM_AXES],
  output logic [pscn_pkg::STATUS_BITS-1:0] status_o
);
  import pscn_pkg::*;

  localparam logic signed [VAL_W-1:0] SAT_HI =
    $signed({{(VAL_W - OUT_BITS + 1){1'b0}}, {(OUT_BITS - 1){1'b1}}});
  localparam logic signed [VAL_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [VAL_W-1:0] HALF =
    $signed({{(VAL_W - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}});

  logic signed [VAL_W-1:0]    qx      [NUM_AXES];
  logic signed [VAL_W-1:0]    val     [NUM_AXES];
  logic signed [OUT_BITS-1:0] sat_val [NUM_AXES];
  logic                       all_done;

  logic                       valid_q;
  logic signed [OUT_BITS-1:0] norm_q  [NUM_AXES];
  logic [STATUS_BITS-1:0]     status_q;

  assign all_done = &done_i;

  // A negative centered value rounds toward minus infinity: -q, one less when inexact.
  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      qx[a]  = $signed({{(VAL_W - QUOT_W){1'b0}}, res_i[a].quot});
      val[a] = res_i[a].neg
             ? -qx[a] - $signed({{(VAL_W - 1){1'b0}}, res_i[a].inexact})
             : qx[a];
      val[a] = val[a] + (center_i ? HALF : '0);
      if (val[a] > SAT_HI) begin
        sat_val[a] = SAT_HI[OUT_BITS-1:0];
      end else if (val[a] < SAT_LO) begin
        sat_val[a] = SAT_LO[OUT_BITS-1:0];
      end else begin
        sat_val[a] = val[a][OUT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= err_i.valid | all_done;
      if (err_i.valid) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          norm_q[a] <= '0;
        end
        status_q <= err_i.status;
      end else if (all_done) begin
        for (int a = 0; a < NUM_AXES; a++) begin
          norm_q[a] <= sat_val[a];
        end
        status_q <= STATUS_OK;
      end
    end
  end

  assign valid_o  = valid_q;
  assign norm_o   = norm_q;
  assign status_o = status_q;

endmodule

// ----- hw/rtl/point_set_unit_cube_normalize_unit.sv -----
`timescale 1ns / 1ps
// Top level of the point set normalizer: point store, bounding box, control, lanes.
// Depends on pscn_pkg, pscn_lane, pscn_merge and the assertion macro header.
//
//   channel   signals                                         direction
//   command   start, busy, kind_i, coord_{x,y,z}_i, point_index_i   in
//   result    res_valid_o, norm_{x,y,z}_o, status_o               out
//   config    cfg_we_i, cfg_idx_i, cfg_wdata_i                    in
//
// Load, clear and unused items leave busy low.
// A read that hits an unloaded index or a flat box returns its item in the next cycle.
// Other reads hold busy while the lanes work and the item appears in the cycle busy drops;
// the 33 steps of each lane's restoring divider set how long such a read takes.
// The three axis lanes run in lockstep. The result has no back-pressure: it is shown
// for exactly one cycle. Reset is asynchronous; the store needs no clearing pass.
`include "point_set_unit_cube_normalize_unit_macros.svh"
module point_set_unit_cube_normalize_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [pscn_pkg::KIND_BITS-1:0]     kind_i,
  input  logic signed [pscn_pkg::COORD_BITS-1:0] coord_x_i,
  input  logic signed [pscn_pkg::COORD_BITS-1:0] coord_y_i,
  input  logic signed [pscn_pkg::COORD_BITS-1:0] coord_z_i,
  input  logic [pscn_pkg::INDEX_BITS-1:0]    point_index_i,
  output logic                               res_valid_o,
  output logic signed [pscn_pkg::OUT_BITS-1:0] norm_x_o,
  output logic signed [pscn_pkg::OUT_BITS-1:0] norm_y_o,
  output logic signed [pscn_pkg::OUT_BITS-1:0] norm_z_o,
  output logic [pscn_pkg::STATUS_BITS-1:0]   status_o,
  input  logic                               cfg_we_i,
  input  logic [pscn_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [pscn_pkg::CFG_DATA_BITS-1:0] cfg_wdata_i
);
  import pscn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WAIT
  } top_state_e;

  top_state_e            state_q;
  logic [CNT_W-1:0]      count_q;
  coord_t                box_min_q [NUM_AXES];
  coord_t                box_max_q [NUM_AXES];
  logic [SCALE_BITS-1:0] scale_q;
  logic                  center_q;

  logic [STORE_W-1:0]    mem [MAX_POINTS];
  logic [STORE_W-1:0]    rd_q;

  logic                  accept;
  kind_e                 kind;
  coord_t                in_coord [NUM_AXES];
  logic                  store_full;
  logic                  idx_miss;
  logic                  box_flat;
  logic                  do_load;
  logic                  do_read;
  err_req_t              err;

  logic [COORD_BITS:0]   ext_diff [NUM_AXES];
  logic [COORD_BITS-1:0] ext      [NUM_AXES];
  logic [COORD_BITS-1:0] emax;
  lane_cmd_t             lane_cmd;
  logic [NUM_AXES-1:0]   lane_done;
  lane_res_t             lane_res [NUM_AXES];
  logic signed [OUT_BITS-1:0] norm [NUM_AXES];

  assign busy   = state_q != ST_IDLE;
  assign accept = start && !busy;
  assign kind   = kind_e'(kind_i);

  always_comb begin
    in_coord[0] = coord_x_i;
    in_coord[1] = coord_y_i;
    in_coord[2] = coord_z_i;
  end

  assign store_full = count_q == CNT_W'(MAX_POINTS);
  assign idx_miss   = 32'(point_index_i) >= 32'(count_q);

  always_comb begin
    box_flat = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if (box_max_q[a] != box_min_q[a]) begin
        box_flat = 1'b0;
      end
    end
  end

  assign do_load    = accept && (kind == KIND_LOAD) && !store_full;
  assign do_read    = accept && (kind == KIND_READ) && !idx_miss && !box_flat;
  assign err.valid  = accept && (kind == KIND_READ) && (idx_miss || box_flat);
  assign err.status = idx_miss ? STATUS_NO_POINT : STATUS_FLAT;

  // Point store: one write port for loads, one registered read port for reads.
  always_ff @(posedge clk_i) begin
    if (do_load) begin
      mem[count_q[ADDR_W-1:0]] <= {coord_z_i, coord_y_i, coord_x_i};
    end
    if (do_read) begin
      rd_q <= mem[ADDR_W'(point_index_i)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      scale_q  <= SCALE_RESET;
      center_q <= 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
        box_min_q[a] <= COORD_MAX;
        box_max_q[a] <= COORD_MIN;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SCALE:  scale_q  <= cfg_wdata_i[SCALE_BITS-1:0];
          CFG_CENTER: center_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            unique case (kind)
              KIND_LOAD: begin
                if (!store_full) begin
                  count_q <= count_q + 1'b1;
                  for (int a = 0; a < NUM_AXES; a++) begin
                    if (in_coord[a] < box_min_q[a]) begin
                      box_min_q[a] <= in_coord[a];
                    end
                    if (in_coord[a] > box_max_q[a]) begin
                      box_max_q[a] <= in_coord[a];
                    end
                  end
                end
              end
              KIND_CLEAR: begin
                count_q <= '0;
                for (int a = 0; a < NUM_AXES; a++) begin
                  box_min_q[a] <= COORD_MAX;
                  box_max_q[a] <= COORD_MIN;
                end
              end
              KIND_READ: begin
                if (do_read) begin
                  state_q <= ST_FETCH;
                end
              end
              default: ;
            endcase
          end
        end
        ST_FETCH: begin
          state_q <= ST_WAIT;
        end
        ST_WAIT: begin
          if (lane_done[0]) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Box extents are stable while a read is in flight; only loads and clears move the box.
  always_comb begin
    emax = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      ext_diff[a] = $unsigned($signed({box_max_q[a][COORD_BITS-1], box_max_q[a]})
                            - $signed({box_min_q[a][COORD_BITS-1], box_min_q[a]}));
      ext[a]      = ext_diff[a][COORD_BITS-1:0];
      if (ext[a] > emax) begin
        emax = ext[a];
      end
    end
  end

  assign lane_cmd.start   = state_q == ST_FETCH;
  assign lane_cmd.center  = center_q;
  assign lane_cmd.scale   = scale_q;
  assign lane_cmd.divisor = center_q ? {emax, 1'b0} : {1'b0, emax};

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
    pscn_lane u_lane (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (lane_cmd),
      .coord_i   (rd_q[g*COORD_BITS +: COORD_BITS]),
      .box_min_i (box_min_q[g]),
      .ext_i     (ext[g]),
      .done_o    (lane_done[g]),
      .res_o     (lane_res[g])
    );
  end

  pscn_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .done_i   (lane_done),
    .res_i    (lane_res),
    .center_i (center_q),
    .err_i    (err),
    .valid_o  (res_valid_o),
    .norm_o   (norm),
    .status_o (status_o)
  );

  assign norm_x_o = norm[0];
  assign norm_y_o = norm[1];
  assign norm_z_o = norm[2];

  `PSCN_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_POINTS))
  `PSCN_ASSERT(a_lanes_lockstep, lane_done[0] |-> &lane_done)
  `PSCN_ASSERT_NEXT(a_read_result, lane_done[0], res_valid_o && status_o == STATUS_OK)
  `PSCN_ASSERT(a_result_when_idle, res_valid_o |-> !busy)

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for point_set_unit_cube_normalize_unit: loads, reads and clears
// with random pacing, predicted by an in-bench bounding-box normalizer. Needs pscn_pkg.
module tb;
  import pscn_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 80;
  localparam int unsigned FILL_PHASE  = 3;
  localparam logic [KIND_BITS-1:0]    KIND_UNUSED = 2'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE_HI = 2'd3;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start;
  logic                         busy;
  logic [KIND_BITS-1:0]         kind_i;
  coord_t                       coord_x_i, coord_y_i, coord_z_i;
  logic [INDEX_BITS-1:0]        point_index_i;
  logic                         res_valid_o;
  logic signed [OUT_BITS-1:0]   norm_x_o, norm_y_o, norm_z_o;
  logic [STATUS_BITS-1:0]       status_o;
  logic                         cfg_we_i;
  logic [CFG_IDX_BITS-1:0]      cfg_idx_i;
  logic [CFG_DATA_BITS-1:0]     cfg_wdata_i;

  typedef struct {
    logic signed [OUT_BITS-1:0] x, y, z;
    status_e                    status;
  } norm_point_t;

  // Tracks the store, the bounding box and the registers, and queues the normalized
  // point that each accepted read must produce.
  class cube_mapper;
    longint                store [MAX_POINTS][NUM_AXES];
    longint                lo [NUM_AXES];
    longint                hi [NUM_AXES];
    int unsigned           point_total;
    logic [SCALE_BITS-1:0] scale;
    logic                  center;
    norm_point_t           pending_points [$];
    int unsigned           mismatches;
    int unsigned           compared;

    function new();
      clear_box();
      scale = SCALE_RESET;
      center = 1'b0;
      mismatches = 0;
      compared = 0;
    endfunction

    function void clear_box();
      point_total = 0;
      for (int a = 0; a < NUM_AXES; a++) begin
        lo[a] = COORD_MAX;
        hi[a] = COORD_MIN;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_SCALE:  scale = data[SCALE_BITS-1:0];
        CFG_CENTER: center = data[0];
        default: ;
      endcase
    endfunction

    // Exact quotient, floored once; center mode works on (2d - e) / 2E around one half.
    function logic signed [OUT_BITS-1:0] map_axis(longint d, longint e, longint emax);
      longint n, mag, num, den, q, v;
      if (!center) begin
        num = d * longint'(scale) * (64'sd1 << SHIFT_S);
        v = num / emax;
      end else begin
        n = 2 * d - e;
        mag = (n < 0) ? -n : n;
        num = mag * longint'(scale) * (64'sd1 << SHIFT_S);
        den = 2 * emax;
        q = num / den;
        if (n < 0) v = -q - (((num % den) != 0) ? 1 : 0);
        else v = q;
        v += 64'sd1 << (FRAC_BITS - 1);
      end
      if (v > (64'sd1 << (OUT_BITS - 1)) - 1) v = (64'sd1 << (OUT_BITS - 1)) - 1;
      if (v < -(64'sd1 << (OUT_BITS - 1))) v = -(64'sd1 << (OUT_BITS - 1));
      return v[OUT_BITS-1:0];
    endfunction

    function void take_item(logic [KIND_BITS-1:0] kind, coord_t x, coord_t y, coord_t z,
                            logic [INDEX_BITS-1:0] idx);
      longint      c [NUM_AXES];
      longint      ext [NUM_AXES];
      longint      emax;
      norm_point_t want;
      c[0] = x;
      c[1] = y;
      c[2] = z;
      case (kind)
        KIND_LOAD: begin
          // A full store ignores further loads.
          if (point_total < MAX_POINTS) begin
            for (int a = 0; a < NUM_AXES; a++) begin
              store[point_total][a] = c[a];
              if (c[a] < lo[a]) lo[a] = c[a];
              if (c[a] > hi[a]) hi[a] = c[a];
            end
            point_total++;
          end
        end
        KIND_CLEAR: clear_box();
        KIND_READ: begin
          want.x = '0;
          want.y = '0;
          want.z = '0;
          emax = 0;
          if (idx >= point_total) begin
            want.status = STATUS_NO_POINT;
          end else begin
            for (int a = 0; a < NUM_AXES; a++) begin
              ext[a] = hi[a] - lo[a];
              if (ext[a] > emax) emax = ext[a];
            end
            if (emax == 0) begin
              want.status = STATUS_FLAT;
            end else begin
              want.status = STATUS_OK;
              want.x = map_axis(store[idx][0] - lo[0], ext[0], emax);
              want.y = map_axis(store[idx][1] - lo[1], ext[1], emax);
              want.z = map_axis(store[idx][2] - lo[2], ext[2], emax);
            end
          end
          pending_points = {pending_points, want};
        end
        default: ;
      endcase
    endfunction

    function void flag(string field, longint want, longint got);
      mismatches++;
      $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
    endfunction

    function void compare_point(logic signed [OUT_BITS-1:0] x, logic signed [OUT_BITS-1:0] y,
                                logic signed [OUT_BITS-1:0] z, logic [STATUS_BITS-1:0] st);
      norm_point_t want;
      if (pending_points.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected point x=%0d y=%0d z=%0d status=%0d",
                 $time, x, y, z, st);
        return;
      end
      want = pending_points.pop_front();
      compared++;
      if (x !== want.x) flag("norm_x", want.x, x);
      if (y !== want.y) flag("norm_y", want.y, y);
      if (z !== want.z) flag("norm_z", want.z, z);
      if (st !== want.status) flag("status", want.status, st);
    endfunction
  endclass

  cube_mapper  norm_points;
  int unsigned idle_pct = 0;
  int unsigned item_total = 0;
  int unsigned cycle_count = 0;

  point_set_unit_cube_normalize_unit DUT (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .coord_x_i, .coord_y_i, .coord_z_i,
    .point_index_i, .res_valid_o, .norm_x_o, .norm_y_o, .norm_z_o, .status_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Results cannot be held off, so every strobe is taken at the edge that ends it.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o)
      norm_points.compare_point(norm_x_o, norm_y_o, norm_z_o, status_o);
  end

  function automatic coord_t any_coord();
    return coord_t'($urandom);
  endfunction

  function automatic logic [INDEX_BITS-1:0] any_index();
    return INDEX_BITS'($urandom);
  endfunction

  function automatic logic [INDEX_BITS-1:0] read_index();
    if (norm_points.point_total > 0 && $urandom_range(0, 9) != 0)
      return INDEX_BITS'($urandom_range(0, norm_points.point_total - 1));
    return any_index();
  endfunction

  function automatic coord_t pick_coord(int style, coord_t base, int span);
    case (style)
      0: return any_coord();
      1: return base + coord_t'($urandom_range(0, span));
      2: begin
        case ($urandom_range(0, 4))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return coord_t'(0);
          3: return coord_t'(-1);
          default: return coord_t'(1);
        endcase
      end
      default: return base;
    endcase
  endfunction

  task automatic issue(input logic [KIND_BITS-1:0] kind, input coord_t x, input coord_t y,
                       input coord_t z, input logic [INDEX_BITS-1:0] idx);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    kind_i <= kind;
    coord_x_i <= x;
    coord_y_i <= y;
    coord_z_i <= z;
    point_index_i <= idx;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    norm_points.take_item(kind, x, y, z, idx);
    item_total++;
  endtask

  // Holds the sender back until every queued point has come out and the block is idle.
  task automatic drain();
    start <= 1'b0;
    while (norm_points.pending_points.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [SCALE_BITS-1:0] scale, input logic center_bit);
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    // The spare indexes go last so that an aliased decode would clobber a real register.
    for (int w = 0; w < 4; w++) begin
      data = CFG_DATA_BITS'($urandom);
      case (w)
        0: begin idx = CFG_SCALE; data = scale; end
        1: begin idx = CFG_CENTER; data[0] = center_bit; end
        2: idx = CFG_SPARE_LO;
        default: idx = CFG_SPARE_HI;
      endcase
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx;
      cfg_wdata_i <= data;
      @(posedge clk_i);
      norm_points.write_reg(idx, data);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_directed();
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd0);
    issue(KIND_LOAD, COORD_MAX, COORD_MIN, coord_t'(0), any_index());
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd0);
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd1023);
    issue(KIND_LOAD, COORD_MIN, COORD_MAX, coord_t'(-1), any_index());
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd0);
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd1);
    issue(KIND_UNUSED, COORD_MIN, COORD_MIN, COORD_MIN, 10'd1023);
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd2);
    issue(KIND_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX, 10'd1023);
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd0);
    // Only x spreads here, so y and z have zero extent inside a valid box.
    issue(KIND_LOAD, coord_t'(5), coord_t'(5), coord_t'(5), any_index());
    issue(KIND_LOAD, coord_t'(7), coord_t'(5), coord_t'(5), any_index());
    issue(KIND_LOAD, coord_t'(6), coord_t'(5), coord_t'(5), any_index());
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd0);
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd1);
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd2);
    issue(KIND_LOAD, coord_t'(-3), coord_t'(100), coord_t'(-8), any_index());
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd3);
  endtask

  // One burst: usually a clear, a batch of loads with a chosen spread, then reads; else a run of random kinds.
  task automatic run_burst();
    int     style, span;
    coord_t bx, by, bz;
    style = $urandom_range(0, 4);
    if (style == 4) begin
      repeat ($urandom_range(3, 10))
        issue(KIND_BITS'($urandom), any_coord(), any_coord(), any_coord(), any_index());
      return;
    end
    if ($urandom_range(0, 3) != 0)
      issue(KIND_CLEAR, any_coord(), any_coord(), any_coord(), any_index());
    span = 1 << $urandom_range(0, 20);
    bx = coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    by = coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    bz = coord_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    repeat ($urandom_range(1, 20))
      issue(KIND_LOAD, pick_coord(style, bx, span), pick_coord(style, by, span),
            pick_coord(style, bz, span), any_index());
    repeat ($urandom_range(1, 8))
      issue(KIND_READ, any_coord(), any_coord(), any_coord(), read_index());
  endtask

  task automatic fill_store();
    issue(KIND_CLEAR, any_coord(), any_coord(), any_coord(), any_index());
    repeat (MAX_POINTS + 6)
      issue(KIND_LOAD, any_coord(), any_coord(), any_coord(), any_index());
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), INDEX_BITS'(MAX_POINTS - 1));
    issue(KIND_READ, any_coord(), any_coord(), any_coord(), 10'd0);
    repeat (40) issue(KIND_READ, any_coord(), any_coord(), any_coord(), read_index());
  endtask

  initial begin
    logic [SCALE_BITS-1:0] scale;
    logic                  center_bit;
    int unsigned           target;
    norm_points = new();
    rst_ni <= 1'b0;
    start <= 1'b0;
    kind_i <= KIND_LOAD;
    coord_x_i <= '0;
    coord_y_i <= '0;
    coord_z_i <= '0;
    point_index_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_SCALE;
    cfg_wdata_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin scale = 16'hFFFF; center_bit = 1'b1; idle_pct = 0; end
        1: begin scale = 16'd1; center_bit = 1'b0; idle_pct = 88; end
        2: begin scale = 16'd0; center_bit = 1'b1; idle_pct = 7; end
        3: begin scale = SCALE_BITS'($urandom_range(1, 65535)); center_bit = 1'b0;
                 idle_pct = 7; end
        4: begin scale = SCALE_BITS'($urandom_range(1, 65535)); center_bit = 1'b1;
                 idle_pct = 88; end
        default: begin scale = 16'hFFFF; center_bit = 1'b0; idle_pct = 0; end
      endcase
      drain();
      configure(scale, center_bit);
      if (p == FILL_PHASE) begin
        fill_store();
      end else begin
        target = item_total + PHASE_ITEMS;
        while (item_total < target) run_burst();
      end
    end

    drain();
    repeat (45) @(posedge clk_i);
    $display("Run: %0d items accepted, %0d normalized points compared.",
             item_total, norm_points.compared);
    $display("Covered empty, flat and full stores, unused kind, scale 0 to 65535, "
             , "both center modes and sender idling of 0, 7 and 88 percent.");
    if (norm_points.mismatches == 0 && norm_points.pending_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pscn_pkg.sv
hw/rtl/pscn_lane.sv
hw/rtl/pscn_merge.sv
hw/rtl/point_set_unit_cube_normalize_unit.sv
tb/sv/tb.sv
